>>> hw/rtl/gbsd_pkg.sv
package gbsd_pkg;

    localparam int BTN_W    = 12;
    localparam int AXIS_W   = 12;
    localparam int STICK_W  = 16;
    localparam int Q_BITS   = 15;
    localparam int CNT_W    = $clog2(Q_BITS);
    localparam int IN_W     = 80;
    localparam int OUT_W    = 72;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam int FIFO_PTR_W = 1;
    localparam int FIFO_DEPTH = 2 ** FIFO_PTR_W;

    localparam logic [STICK_W-1:0] SAT_MAX = 16'd32767;

    localparam logic [CFG_IDX_W-1:0] CFG_IS_LEFT       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_ABOVE_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_ABOVE_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_BELOW_X = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_BELOW_Y = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE     = 3'd7;

    typedef struct packed {
        logic              is_left;
        logic [AXIS_W-1:0] center_x;
        logic [AXIS_W-1:0] center_y;
        logic [AXIS_W-1:0] range_above_x;
        logic [AXIS_W-1:0] range_above_y;
        logic [AXIS_W-1:0] range_below_x;
        logic [AXIS_W-1:0] range_below_y;
        logic [AXIS_W-1:0] dead_zone;
    } cfg_t;

    typedef struct packed {
        logic              neg;
        logic              zero;
        logic              sat;
        logic [AXIS_W-1:0] mag;
        logic [AXIS_W-1:0] span;
    } lane_t;

    typedef struct packed {
        logic [BTN_W-1:0] buttons;
        logic [BTN_W-1:0] pressed;
        logic [BTN_W-1:0] released;
        lane_t            x;
        lane_t            y;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } back_state_t;

    function automatic lane_t lane_prep(
        input logic [AXIS_W-1:0] raw,
        input logic [AXIS_W-1:0] centre,
        input logic [AXIS_W-1:0] above,
        input logic [AXIS_W-1:0] below,
        input logic [AXIS_W-1:0] dz
    );
        lane_t l;
        l.neg  = raw < centre;
        l.mag  = l.neg ? centre - raw : raw - centre;
        l.span = l.neg ? below : above;
        l.zero = (l.mag < dz) || (l.mag == '0);
        // quotient reaches 2**(Q_BITS) once mag >= 2*span
        l.sat  = (l.span == '0) || ({1'b0, l.mag} >= {l.span, 1'b0});
        return l;
    endfunction

    function automatic logic [AXIS_W:0] div_step(
        input logic [AXIS_W-1:0] r,
        input logic              din,
        input logic [AXIS_W-1:0] span
    );
        logic [AXIS_W:0] t;
        logic [AXIS_W:0] d;
        t = {r, din};
        d = t - {1'b0, span};
        if (t >= {1'b0, span})
        begin
            return {d[AXIS_W-1:0], 1'b1};
        end
        return {t[AXIS_W-1:0], 1'b0};
    endfunction

    function automatic logic [STICK_W-1:0] lane_result(
        input lane_t             l,
        input logic [Q_BITS-1:0] q
    );
        logic [STICK_W-1:0] v;
        if (l.zero)
        begin
            v = '0;
        end
        else if (l.sat)
        begin
            v = SAT_MAX;
        end
        else
        begin
            v = {{(STICK_W-Q_BITS){1'b0}}, q};
        end
        if (l.neg)
        begin
            v = STICK_W'(0) - v;
        end
        return v;
    endfunction

endpackage

>>> hw/rtl/gbsd_front.sv
module gbsd_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  gbsd_pkg::cfg_t          cfg,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [gbsd_pkg::IN_W-1:0] s_tdata,
    input  gbsd_pkg::fifo_stat_t    fifo_stat,
    output logic                    push,
    output gbsd_pkg::entry_t        push_entry
);

    logic [gbsd_pkg::BTN_W-1:0] prev_reg;
    logic [gbsd_pkg::BTN_W-1:0] prev_next;
    logic [gbsd_pkg::BTN_W-1:0] cur;
    logic [7:0] id, b3, b4, b5, s0, s1, s2, bb;
    logic [gbsd_pkg::AXIS_W-1:0] rx, ry;

    assign id = s_tdata[7:0];
    assign b3 = s_tdata[15:8];
    assign b4 = s_tdata[23:16];
    assign b5 = s_tdata[31:24];

    assign s_tready = !fifo_stat.full;

    always_comb
    begin
        if (cfg.is_left)
        begin
            s0 = s_tdata[39:32];
            s1 = s_tdata[47:40];
            s2 = s_tdata[55:48];
            bb = b5;
            cur[0] = bb[0];
            cur[1] = bb[2];
            cur[2] = bb[1];
            cur[3] = bb[3];
            cur[7] = b4[3];
        end
        else
        begin
            s0 = s_tdata[63:56];
            s1 = s_tdata[71:64];
            s2 = s_tdata[79:72];
            bb = b3;
            cur[0] = bb[2];
            cur[1] = bb[3];
            cur[2] = bb[1];
            cur[3] = bb[0];
            cur[7] = b4[2];
        end
        cur[4]  = b4[4];
        cur[5]  = b4[0];
        cur[6]  = b4[1];
        cur[8]  = bb[6];
        cur[9]  = bb[7];
        cur[10] = bb[4];
        cur[11] = bb[5];
        rx = {s1[3:0], s0};
        ry = {s2, s1[7:4]};
    end

    always_comb
    begin
        push = s_tvalid && s_tready && (id != 8'd0);
        push_entry.buttons  = cur;
        push_entry.pressed  = ~prev_reg & cur;
        push_entry.released = prev_reg & ~cur;
        push_entry.x = gbsd_pkg::lane_prep(rx, cfg.center_x, cfg.range_above_x,
                                           cfg.range_below_x, cfg.dead_zone);
        push_entry.y = gbsd_pkg::lane_prep(ry, cfg.center_y, cfg.range_above_y,
                                           cfg.range_below_y, cfg.dead_zone);
        prev_next = push ? cur : prev_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
        end
        else
        begin
            prev_reg <= prev_next;
        end
    end

endmodule

>>> hw/rtl/gbsd_fifo.sv
module gbsd_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  gbsd_pkg::entry_t     push_entry,
    input  logic                 pop,
    output gbsd_pkg::entry_t     head,
    output gbsd_pkg::fifo_stat_t stat
);

    localparam int CNT_W = gbsd_pkg::FIFO_PTR_W + 1;

    gbsd_pkg::entry_t mem_reg [gbsd_pkg::FIFO_DEPTH];
    logic [gbsd_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [gbsd_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign stat.full  = (count_reg == CNT_W'(gbsd_pkg::FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head = mem_reg[rd_ptr_reg];

    always_comb
    begin
        do_push = push && !stat.full;
        do_pop  = pop && !stat.empty;
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> hw/rtl/gbsd_back.sv
module gbsd_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  gbsd_pkg::fifo_stat_t        fifo_stat,
    input  gbsd_pkg::entry_t            head,
    output logic                        pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [gbsd_pkg::OUT_W-1:0]  m_tdata
);

    localparam int AW = gbsd_pkg::AXIS_W;
    localparam int QW = gbsd_pkg::Q_BITS;
    localparam int CW = gbsd_pkg::CNT_W;

    gbsd_pkg::back_state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    gbsd_pkg::entry_t ent_reg, ent_next;
    logic [AW-1:0] rx_reg, rx_next, ry_reg, ry_next;
    logic [QW-1:0] qx_reg, qx_next, qy_reg, qy_next;
    logic [QW-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic out_valid_reg, out_valid_next;
    logic [gbsd_pkg::OUT_W-1:0] out_reg, out_next;
    logic [AW:0] stx, sty;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    assign stx = gbsd_pkg::div_step(rx_reg, dx_reg[QW-1], ent_reg.x.span);
    assign sty = gbsd_pkg::div_step(ry_reg, dy_reg[QW-1], ent_reg.y.span);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ent_next   = ent_reg;
        rx_next = rx_reg;
        ry_next = ry_reg;
        qx_next = qx_reg;
        qy_next = qy_reg;
        dx_next = dx_reg;
        dy_next = dy_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg && !m_tready;
        pop = 1'b0;
        case (state_reg)
            gbsd_pkg::BK_IDLE:
            begin
                if (!fifo_stat.empty)
                begin
                    pop      = 1'b1;
                    ent_next = head;
                    rx_next  = {1'b0, head.x.mag[AW-1:1]};
                    ry_next  = {1'b0, head.y.mag[AW-1:1]};
                    dx_next  = {head.x.mag[0], {(QW-1){1'b0}}};
                    dy_next  = {head.y.mag[0], {(QW-1){1'b0}}};
                    cnt_next = CW'(QW - 1);
                    state_next = gbsd_pkg::BK_DIV;
                end
            end
            gbsd_pkg::BK_DIV:
            begin
                rx_next = stx[AW:1];
                ry_next = sty[AW:1];
                qx_next = {qx_reg[QW-2:0], stx[0]};
                qy_next = {qy_reg[QW-2:0], sty[0]};
                dx_next = {dx_reg[QW-2:0], 1'b0};
                dy_next = {dy_reg[QW-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = gbsd_pkg::BK_DONE;
                end
            end
            gbsd_pkg::BK_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_next = {4'b0,
                                gbsd_pkg::lane_result(ent_reg.y, qy_reg),
                                gbsd_pkg::lane_result(ent_reg.x, qx_reg),
                                ent_reg.released, ent_reg.pressed, ent_reg.buttons};
                    out_valid_next = 1'b1;
                    state_next = gbsd_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = gbsd_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gbsd_pkg::BK_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
        rx_reg  <= rx_next;
        ry_reg  <= ry_next;
        qx_reg  <= qx_next;
        qy_reg  <= qy_next;
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        out_reg <= out_next;
    end

endmodule

>>> hw/rtl/gamepad_button_stick_decoder.sv
// Channel  Dir  Width  Beat contents
// s_axis   in   80     controller report bytes
// m_axis   out  72     decoded buttons, edges and centered sticks
// cfg      in   3+12   register write, index and data
//
// After a report is accepted, the back end pops it from the queue, runs fifteen steps
// of the two restoring dividers and loads the output register; it takes no new report
// until that result is loaded. Reports with id zero are dropped. Reset clears the
// previous button vector, the queue and the output valid, and sets the registers to
// their defaults. A stalled output holds its beat while the next report divides; the
// input stalls when the two-entry queue is full.
module gamepad_button_stick_decoder (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [gbsd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gbsd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // report_id, byte3, byte4, byte5, byte6 .. byte11
    input  logic [gbsd_pkg::IN_W-1:0]          s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // button_state, pressed_edges, released_edges, stick_x, stick_y, pad
    output logic [gbsd_pkg::OUT_W-1:0]         m_tdata
);

    gbsd_pkg::cfg_t       cfg_reg;
    gbsd_pkg::fifo_stat_t fifo_stat;
    gbsd_pkg::entry_t     push_entry;
    gbsd_pkg::entry_t     head;
    logic                 push;
    logic                 pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.is_left       <= 1'b1;
            cfg_reg.center_x      <= 12'd2048;
            cfg_reg.center_y      <= 12'd2048;
            cfg_reg.range_above_x <= 12'd1400;
            cfg_reg.range_above_y <= 12'd1400;
            cfg_reg.range_below_x <= 12'd1400;
            cfg_reg.range_below_y <= 12'd1400;
            cfg_reg.dead_zone     <= 12'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gbsd_pkg::CFG_IS_LEFT:       cfg_reg.is_left       <= cfg_data[0];
                gbsd_pkg::CFG_CENTER_X:      cfg_reg.center_x      <= cfg_data;
                gbsd_pkg::CFG_CENTER_Y:      cfg_reg.center_y      <= cfg_data;
                gbsd_pkg::CFG_RANGE_ABOVE_X: cfg_reg.range_above_x <= cfg_data;
                gbsd_pkg::CFG_RANGE_ABOVE_Y: cfg_reg.range_above_y <= cfg_data;
                gbsd_pkg::CFG_RANGE_BELOW_X: cfg_reg.range_below_x <= cfg_data;
                gbsd_pkg::CFG_RANGE_BELOW_Y: cfg_reg.range_below_y <= cfg_data;
                gbsd_pkg::CFG_DEAD_ZONE:     cfg_reg.dead_zone     <= cfg_data;
                default:                     cfg_reg.dead_zone     <= cfg_reg.dead_zone;
            endcase
        end
    end

    gbsd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .fifo_stat  (fifo_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    gbsd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .stat       (fifo_stat)
    );

    gbsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .fifo_stat (fifo_stat),
        .head      (head),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tdata[7:0] != 8'd0) |=> !fifo_stat.empty)
        else $error("accepted report missing from queue");

    a_no_min_stick: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[51:36] != 16'h8000 && m_tdata[67:52] != 16'h8000))
        else $error("stick value outside saturation range");

    a_edges_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[23:12] & m_tdata[35:24]) == 12'd0))
        else $error("button both pressed and released");

endmodule

>>> tb/tb_gamepad_button_stick_decoder.sv
module tb_gamepad_button_stick_decoder;

    localparam int RPT_W         = 80;
    localparam int MAX_GAP       = 18;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 5000;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 100;
    localparam logic [15:0] AXIS_MAX = 16'd32767;

    typedef struct packed {
        logic [11:0] buttons;
        logic [11:0] pressed;
        logic [11:0] released;
        logic [15:0] stick_x;
        logic [15:0] stick_y;
    } report_out_t;

    typedef enum logic {
        ROW_REPORT,
        ROW_REG
    } row_kind_t;

    typedef struct {
        row_kind_t                        kind;
        logic [gbsd_pkg::CFG_IDX_W-1:0]   idx;
        logic [gbsd_pkg::CFG_DATA_W-1:0]  val;
        logic [RPT_W-1:0]                 data;
        bit                               typed;
        report_out_t                      want;
    } directed_row_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [gbsd_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [gbsd_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    // report_id, byte3, byte4, byte5, byte6 .. byte11
    logic [gbsd_pkg::IN_W-1:0]        s_tdata = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    // button_state, pressed_edges, released_edges, stick_x, stick_y, pad
    logic [gbsd_pkg::OUT_W-1:0]       m_tdata;

    gbsd_pkg::cfg_t         cfg_now;
    logic [11:0]            last_buttons = '0;
    report_out_t            pending_reports[$];
    directed_row_t          directed_rows[$];
    int                     errors = 0;
    int                     stall_cycles = 0;
    bit                     src_idle = 1'b0;
    bit                     snk_idle = 1'b0;
    bit                     hold_req = 1'b0;

    gamepad_button_stick_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    function automatic logic [15:0] scale_axis(
        input logic [11:0] raw,
        input logic [11:0] centre,
        input logic [11:0] above,
        input logic [11:0] below,
        input logic [11:0] dz
    );
        logic        neg;
        logic [11:0] mag;
        logic [11:0] span;
        logic [31:0] q;
        neg  = raw < centre;
        mag  = neg ? centre - raw : raw - centre;
        span = neg ? below : above;
        if (mag < dz || mag == 12'd0)
        begin
            return 16'd0;
        end
        if (span == 12'd0)
        begin
            q = {16'd0, AXIS_MAX};
        end
        else
        begin
            q = ({20'd0, mag} << 14) / {20'd0, span};
            if (q > {16'd0, AXIS_MAX})
            begin
                q = {16'd0, AXIS_MAX};
            end
        end
        if (neg)
        begin
            q = 32'd0 - q;
        end
        return q[15:0];
    endfunction

    function automatic report_out_t decode_report(input logic [RPT_W-1:0] d);
        logic [7:0]  b4;
        logic [7:0]  bb;
        logic [7:0]  s0;
        logic [7:0]  s1;
        logic [7:0]  s2;
        logic [11:0] btn;
        logic [11:0] rx;
        logic [11:0] ry;
        report_out_t r;
        b4 = d[23:16];
        if (cfg_now.is_left)
        begin
            bb     = d[31:24];
            s0     = d[39:32];
            s1     = d[47:40];
            s2     = d[55:48];
            btn[0] = bb[0];
            btn[1] = bb[2];
            btn[2] = bb[1];
            btn[3] = bb[3];
            btn[7] = b4[3];
        end
        else
        begin
            bb     = d[15:8];
            s0     = d[63:56];
            s1     = d[71:64];
            s2     = d[79:72];
            btn[0] = bb[2];
            btn[1] = bb[3];
            btn[2] = bb[1];
            btn[3] = bb[0];
            btn[7] = b4[2];
        end
        btn[4]  = b4[4];
        btn[5]  = b4[0];
        btn[6]  = b4[1];
        btn[8]  = bb[6];
        btn[9]  = bb[7];
        btn[10] = bb[4];
        btn[11] = bb[5];
        rx = {s1[3:0], s0};
        ry = {s2, s1[7:4]};
        r.buttons  = btn;
        r.pressed  = ~last_buttons & btn;
        r.released = last_buttons & ~btn;
        r.stick_x  = scale_axis(rx, cfg_now.center_x, cfg_now.range_above_x,
                                cfg_now.range_below_x, cfg_now.dead_zone);
        r.stick_y  = scale_axis(ry, cfg_now.center_y, cfg_now.range_above_y,
                                cfg_now.range_below_y, cfg_now.dead_zone);
        return r;
    endfunction

    function automatic logic [RPT_W-1:0] mk_report(
        input logic [7:0] id,
        input logic [7:0] b3,
        input logic [7:0] b4,
        input logic [7:0] b5,
        input logic [7:0] b6,
        input logic [7:0] b7,
        input logic [7:0] b8,
        input logic [7:0] b9,
        input logic [7:0] b10,
        input logic [7:0] b11
    );
        return {b11, b10, b9, b8, b7, b6, b5, b4, b3, id};
    endfunction

    function automatic logic [11:0] pick12(input int typ_hi);
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
        begin
            return 12'd0;
        end
        if (r == 1)
        begin
            return 12'd4095;
        end
        return 12'($urandom_range(0, typ_hi));
    endfunction

    function automatic logic [11:0] near_centre(input logic [11:0] c);
        int off;
        int v;
        off = $urandom_range(0, int'(cfg_now.dead_zone) + 4);
        v   = $urandom_range(0, 1) ? int'(c) + off : int'(c) - off;
        if (v < 0)
        begin
            v = 0;
        end
        if (v > 4095)
        begin
            v = 4095;
        end
        return 12'(v);
    endfunction

    task automatic add_report(input logic [RPT_W-1:0] d, input bit typed,
                              input report_out_t want);
        directed_row_t row;
        row.kind  = ROW_REPORT;
        row.idx   = gbsd_pkg::CFG_IS_LEFT;
        row.val   = '0;
        row.data  = d;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    task automatic add_reg(input logic [gbsd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [11:0] val);
        directed_row_t row;
        row.kind  = ROW_REG;
        row.idx   = idx;
        row.val   = val;
        row.data  = '0;
        row.typed = 1'b0;
        row.want  = '0;
        directed_rows.push_back(row);
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
        errors++;
    endtask

    task automatic check_beat(input logic [gbsd_pkg::OUT_W-1:0] data);
        report_out_t got;
        report_out_t want;
        got.buttons  = data[11:0];
        got.pressed  = data[23:12];
        got.released = data[35:24];
        got.stick_x  = data[51:36];
        got.stick_y  = data[67:52];
        if (pending_reports.size() == 0)
        begin
            report_mismatch("beat with no pending report", 16'(got.buttons), 16'd0);
        end
        else
        begin
            want = pending_reports.pop_front();
            if (got.buttons !== want.buttons)
                report_mismatch("button_state", 16'(got.buttons), 16'(want.buttons));
            if (got.pressed !== want.pressed)
                report_mismatch("pressed_edges", 16'(got.pressed), 16'(want.pressed));
            if (got.released !== want.released)
                report_mismatch("released_edges", 16'(got.released),
                                16'(want.released));
            if (got.stick_x !== want.stick_x)
                report_mismatch("stick_x", got.stick_x, want.stick_x);
            if (got.stick_y !== want.stick_y)
                report_mismatch("stick_y", got.stick_y, want.stick_y);
        end
    endtask

    task automatic send_report(input logic [RPT_W-1:0] d, input bit typed,
                               input report_out_t want);
        int          gap;
        report_out_t r;
        gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        if (d[7:0] != 8'd0)
        begin
            r = decode_report(d);
            last_buttons = r.buttons;
            pending_reports.push_back(typed ? want : r);
        end
    endtask

    // drain everything, then let dropped beats clear the pipe
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [gbsd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [11:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            gbsd_pkg::CFG_IS_LEFT:       cfg_now.is_left       = val[0];
            gbsd_pkg::CFG_CENTER_X:      cfg_now.center_x      = val;
            gbsd_pkg::CFG_CENTER_Y:      cfg_now.center_y      = val;
            gbsd_pkg::CFG_RANGE_ABOVE_X: cfg_now.range_above_x = val;
            gbsd_pkg::CFG_RANGE_ABOVE_Y: cfg_now.range_above_y = val;
            gbsd_pkg::CFG_RANGE_BELOW_X: cfg_now.range_below_x = val;
            gbsd_pkg::CFG_RANGE_BELOW_Y: cfg_now.range_below_y = val;
            gbsd_pkg::CFG_DEAD_ZONE:     cfg_now.dead_zone     = val;
            default: ;
        endcase
    endtask

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == STALL_LIMIT)
        begin
            $display("TIMEOUT: no beat for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int w;
        wait (rst_n);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            w = snk_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (w > 0)
            begin
                m_tready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
            begin
                @(posedge clk);
            end
            check_beat(m_tdata);
        end
    end

    initial
    begin
        bit               in_writes;
        logic [95:0]      raw_bits;
        logic [RPT_W-1:0] d;
        logic [11:0]      rx;
        logic [11:0]      ry;
        int               lane;
        report_out_t      none;

        none      = '0;
        in_writes = 1'b0;
        cfg_now.is_left       = 1'b1;
        cfg_now.center_x      = 12'd2048;
        cfg_now.center_y      = 12'd2048;
        cfg_now.range_above_x = 12'd1400;
        cfg_now.range_above_y = 12'd1400;
        cfg_now.range_below_x = 12'd1400;
        cfg_now.range_below_y = 12'd1400;
        cfg_now.dead_zone     = 12'd0;

        // reset defaults, left mapping, centered sticks
        add_report(mk_report(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08, 8'h80,
                             8'h00, 8'h00, 8'h00), 1'b1, none);
        add_report(mk_report(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                             8'hFF, 8'hFF, 8'hFF), 1'b0, none);
        add_report(mk_report(8'h80, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF,
                             8'h00, 8'h00, 8'h00), 1'b0, none);
        add_report(mk_report(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                             8'h00, 8'h00, 8'h00), 1'b0, none);
        add_report(mk_report(8'h55, 8'hAA, 8'h0A, 8'h55, 8'h34, 8'h12, 8'hAB,
                             8'h00, 8'h00, 8'h00), 1'b0, none);
        add_report(mk_report(8'hAA, 8'h55, 8'h15, 8'hAA, 8'hCD, 8'hEF, 8'h01,
                             8'h00, 8'h00, 8'h00), 1'b0, none);
        add_report(mk_report(8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h08, 8'h80,
                             8'hFF, 8'hFF, 8'hFF), 1'b1,
                   '{12'hFFF, 12'h5C3, 12'h000, 16'd0, 16'd0});
        add_report(mk_report(8'h01, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h08, 8'h80,
                             8'h00, 8'h00, 8'h00), 1'b1,
                   '{12'h000, 12'h000, 12'hFFF, 16'd0, 16'd0});
        // zero spans saturate both ways
        add_reg(gbsd_pkg::CFG_RANGE_ABOVE_X, 12'd0);
        add_reg(gbsd_pkg::CFG_RANGE_ABOVE_Y, 12'd0);
        add_reg(gbsd_pkg::CFG_RANGE_BELOW_X, 12'd0);
        add_reg(gbsd_pkg::CFG_RANGE_BELOW_Y, 12'd0);
        add_report(mk_report(8'h01, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF,
                             8'h00, 8'h00, 8'h00), 1'b1,
                   '{12'h000, 12'h000, 12'h000, 16'h7FFF, 16'h7FFF});
        add_report(mk_report(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                             8'h00, 8'h00, 8'h00), 1'b1,
                   '{12'h000, 12'h000, 12'h000, 16'h8001, 16'h8001});
        add_report(mk_report(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08, 8'h80,
                             8'h00, 8'h00, 8'h00), 1'b1, none);
        // right mapping
        add_reg(gbsd_pkg::CFG_IS_LEFT, 12'd0);
        add_reg(gbsd_pkg::CFG_RANGE_ABOVE_X, 12'd1);
        add_reg(gbsd_pkg::CFG_RANGE_BELOW_Y, 12'd1);
        add_report(mk_report(8'h02, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
                             8'hFF, 8'hFF, 8'hFF), 1'b0, none);
        add_report(mk_report(8'h03, 8'h5A, 8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                             8'h01, 8'h08, 8'h80), 1'b0, none);
        add_report(mk_report(8'h04, 8'hA5, 8'h1B, 8'h00, 8'h00, 8'h00, 8'h00,
                             8'hFF, 8'h07, 8'h7F), 1'b0, none);
        add_reg(gbsd_pkg::CFG_CENTER_X, 12'd0);
        add_reg(gbsd_pkg::CFG_CENTER_Y, 12'd4095);
        add_reg(gbsd_pkg::CFG_RANGE_ABOVE_X, 12'd4095);
        add_reg(gbsd_pkg::CFG_RANGE_BELOW_Y, 12'd4095);
        add_report(mk_report(8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                             8'hFF, 8'hFF, 8'hFF), 1'b0, none);
        add_report(mk_report(8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                             8'h00, 8'h00, 8'h00), 1'b0, none);
        add_report(mk_report(8'h40, 8'h0F, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00,
                             8'h34, 8'h12, 8'hAB), 1'b0, none);
        add_reg(gbsd_pkg::CFG_DEAD_ZONE, 12'd4095);
        add_report(mk_report(8'h7F, 8'hF0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                             8'hFF, 8'h0F, 8'h00), 1'b0, none);
        add_report(mk_report(8'hFE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                             8'h00, 8'h08, 8'h80), 1'b0, none);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_REG)
            begin
                if (!in_writes)
                begin
                    wait_idle();
                end
                write_reg(directed_rows[i].idx, directed_rows[i].val);
                in_writes = 1'b1;
            end
            else
            begin
                if (in_writes)
                begin
                    cfg_we    <= 1'b0;
                    in_writes = 1'b0;
                end
                send_report(directed_rows[i].data, directed_rows[i].typed,
                            directed_rows[i].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            write_reg(gbsd_pkg::CFG_IS_LEFT, {11'd0, ph[0]});
            write_reg(gbsd_pkg::CFG_CENTER_X, pick12(4095));
            write_reg(gbsd_pkg::CFG_CENTER_Y, pick12(4095));
            write_reg(gbsd_pkg::CFG_RANGE_ABOVE_X, pick12(4095));
            write_reg(gbsd_pkg::CFG_RANGE_ABOVE_Y, pick12(4095));
            write_reg(gbsd_pkg::CFG_RANGE_BELOW_X, pick12(4095));
            write_reg(gbsd_pkg::CFG_RANGE_BELOW_Y, pick12(4095));
            write_reg(gbsd_pkg::CFG_DEAD_ZONE, pick12(300));
            cfg_we <= 1'b0;
            src_idle = (ph != 1) && ($urandom_range(0, 3) != 0);
            snk_idle = (ph != 1) && ($urandom_range(0, 3) != 0);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (ph == 2 && i == 10)
                begin
                    hold_req = 1'b1;
                end
                if (ph == 4 && i == 50)
                begin
                    wait_idle();
                end
                raw_bits = {$urandom(), $urandom(), $urandom()};
                d = raw_bits[RPT_W-1:0];
                if ($urandom_range(0, 9) == 0)
                begin
                    d[7:0] = 8'd0;
                end
                else if (d[7:0] == 8'd0)
                begin
                    d[7:0] = 8'd1;
                end
                // steer the active stick around the center and deadzone edge
                if ($urandom_range(0, 1) == 1)
                begin
                    rx   = near_centre(cfg_now.center_x);
                    ry   = near_centre(cfg_now.center_y);
                    lane = cfg_now.is_left ? 32 : 56;
                    d[lane +: 24] = {ry, rx};
                end
                send_report(d, 1'b0, none);
            end
        end

        wait_idle();
        if (errors == 0 && pending_reports.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> gamepad_button_stick_decoder.f
hw/rtl/gbsd_pkg.sv
hw/rtl/gbsd_front.sv
hw/rtl/gbsd_fifo.sv
hw/rtl/gbsd_back.sv
hw/rtl/gamepad_button_stick_decoder.sv
tb/tb_gamepad_button_stick_decoder.sv
